// File: hw/rtl/sorted_set_enter_leave_delta_macros.svh
// Assertion macros shared by the sorted set enter/leave delta RTL.
// No dependencies; included by the controller and the datapath.
`ifndef SORTED_SET_ENTER_LEAVE_DELTA_MACROS_SVH
`define SORTED_SET_ENTER_LEAVE_DELTA_MACROS_SVH
`ifndef SYNTHESIS
`define SSELD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sorted set delta: assertion failed");
`define SSELD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sorted set delta: assertion failed");
`else
`define SSELD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SSELD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/sseld_pkg.sv
// Package for the sorted set enter/leave delta block: sizes, payload types,
// event codes and the controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
package sseld_pkg;

	localparam int LIST_DEPTH = 32;
	localparam int SLOT_COUNT = 16;

	localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int IDX_W  = $clog2(LIST_DEPTH);
	localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
	localparam int MEM_AW = SLOT_W + 1 + IDX_W;
	localparam int MEM_WORDS = 2 ** MEM_AW;

	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);

	localparam logic [1:0] EV_ENTER = 2'd0;
	localparam logic [1:0] EV_LEAVE = 2'd1;
	localparam logic [1:0] EV_DONE  = 2'd2;

	typedef logic [SLOT_W-1:0] slot_idx_t;
	typedef logic [CNT_W-1:0] count_t;

	typedef struct packed {
		logic [3:0]  slot;
		logic [31:0] entity_id;
		logic        has_id;
		logic        end_of_frame;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  event_kind;
		logic [31:0] event_id;
		logic        overflow;
		logic        order_error;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic       load;
		logic       flag_order;
		logic       rd_issue;
		logic       rd_inc;
		logic       store;
		logic       emit;
		logic [1:0] kind;
		logic       commit;
		logic       flush;
	} dp_cmd_t;

	typedef struct packed {
		logic has_id;
		logic eof;
		logic order_bad;
		logic rd_avail;
		logic lt;
		logic eq;
		logic can_emit;
		logic pend_valid;
		logic out_free;
	} dp_status_t;

	typedef slot_idx_t slot_tbl_t [16];

	function automatic slot_tbl_t mk_slot_tbl();
		slot_tbl_t t;
		for (int i = 0; i < 16; i++) begin
			t[i] = slot_idx_t'(i % SLOT_COUNT);
		end
		return t;
	endfunction

	localparam slot_tbl_t SLOT_TBL = mk_slot_tbl();

	function automatic slot_idx_t slot_fold(input logic [3:0] v);
		return SLOT_TBL[v];
	endfunction

endpackage

// File: hw/rtl/sseld_dp.sv
// Datapath of the sorted set enter/leave delta block: id store, per-slot
// counts and banks, merge registers and the two-entry result queue. Uses sseld_pkg.
`timescale 1ns / 1ps
`include "sorted_set_enter_leave_delta_macros.svh"
module sseld_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sseld_pkg::in_item_t   in_data,
	input  sseld_pkg::dp_cmd_t    cmd,
	output sseld_pkg::dp_status_t st,
	output logic                  out_valid,
	input  logic                  out_ready,
	output sseld_pkg::out_item_t  out_data
);
	import sseld_pkg::*;

	in_item_t    item_q;
	slot_idx_t   frame_slot_q;
	logic        in_frame_q;
	count_t      read_index_q;
	count_t      write_count_q;
	logic [31:0] previous_id_q;
	logic        flag_ov_q;
	logic        flag_oe_q;
	logic        bank_q [SLOT_COUNT];
	count_t      count_q [SLOT_COUNT][2];
	logic [31:0] mem [MEM_WORDS];
	logic [31:0] mem_rd_q;
	logic        pend_valid_q;
	out_item_t   pend_q;
	logic        out_valid_q;
	out_item_t   out_q;

	logic        old_bank;
	logic        new_bank;
	count_t      stored_len;
	logic        out_free;
	logic        push;
	logic        room;
	out_item_t   new_item;
	out_item_t   push_item;

	assign old_bank   = bank_q[frame_slot_q];
	assign new_bank   = ~old_bank;
	assign stored_len = count_q[frame_slot_q][old_bank];
	assign out_free   = !out_valid_q || out_ready;
	assign push       = (cmd.emit || cmd.flush) && pend_valid_q;
	assign room       = write_count_q < DEPTH_C;

	always_comb begin
		new_item = '0;
		new_item.event_kind = cmd.kind;
		case (cmd.kind)
			EV_ENTER: new_item.event_id = item_q.entity_id;
			EV_LEAVE: new_item.event_id = mem_rd_q;
			EV_DONE: begin
				new_item.overflow    = flag_ov_q;
				new_item.order_error = flag_oe_q;
			end
			default: new_item.event_id = '0;
		endcase
	end

	always_comb begin
		push_item      = pend_q;
		push_item.last = cmd.flush;
	end

	assign st.has_id     = item_q.has_id;
	assign st.eof        = item_q.end_of_frame;
	assign st.order_bad  = (write_count_q != '0) && (item_q.entity_id <= previous_id_q);
	assign st.rd_avail   = read_index_q < stored_len;
	assign st.lt         = mem_rd_q < item_q.entity_id;
	assign st.eq         = mem_rd_q == item_q.entity_id;
	assign st.can_emit   = !pend_valid_q || out_free;
	assign st.pend_valid = pend_valid_q;
	assign st.out_free   = out_free;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
		end
		if (cmd.rd_issue) begin
			mem_rd_q <= mem[{frame_slot_q, old_bank, read_index_q[IDX_W-1:0]}];
		end
		if (cmd.store && room) begin
			mem[{frame_slot_q, new_bank, write_count_q[IDX_W-1:0]}] <= item_q.entity_id;
		end
		if (cmd.emit) begin
			pend_q <= new_item;
		end
		if (push) begin
			out_q <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_slot_q  <= '0;
			in_frame_q    <= 1'b0;
			read_index_q  <= '0;
			write_count_q <= '0;
			previous_id_q <= '0;
			flag_ov_q     <= 1'b0;
			flag_oe_q     <= 1'b0;
			pend_valid_q  <= 1'b0;
			out_valid_q   <= 1'b0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				bank_q[i]     <= 1'b0;
				count_q[i][0] <= '0;
				count_q[i][1] <= '0;
			end
		end else begin
			if (cmd.load && !in_frame_q) begin
				in_frame_q    <= 1'b1;
				frame_slot_q  <= slot_fold(in_data.slot);
				read_index_q  <= '0;
				write_count_q <= '0;
				previous_id_q <= '0;
				flag_ov_q     <= 1'b0;
				flag_oe_q     <= 1'b0;
			end
			if (cmd.flag_order) begin
				flag_oe_q <= 1'b1;
			end
			if (cmd.rd_inc) begin
				read_index_q <= read_index_q + count_t'(1);
			end
			if (cmd.store) begin
				previous_id_q <= item_q.entity_id;
				if (room) begin
					write_count_q <= write_count_q + count_t'(1);
				end else begin
					flag_ov_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				count_q[frame_slot_q][new_bank] <= write_count_q;
				bank_q[frame_slot_q]            <= new_bank;
				in_frame_q    <= 1'b0;
				read_index_q  <= '0;
				write_count_q <= '0;
				previous_id_q <= '0;
				flag_ov_q     <= 1'b0;
				flag_oe_q     <= 1'b0;
			end
			if (cmd.emit) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_valid_q <= 1'b0;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`SSELD_ASSERT_IMP(a_read_bound, clk, arst_n, 1'b1, read_index_q <= stored_len)
	`SSELD_ASSERT_IMP(a_write_bound, clk, arst_n, 1'b1, write_count_q <= DEPTH_C)
	`SSELD_ASSERT_IMP(a_push_has_room, clk, arst_n, push, out_free)
	`SSELD_ASSERT_NEXT(a_commit_closes, clk, arst_n, cmd.commit, !in_frame_q && read_index_q == '0)

endmodule

// File: hw/rtl/sseld_ctrl.sv
// Controller of the sorted set enter/leave delta block: the merge sequencer
// that drives the datapath by command and reads its status. Uses sseld_pkg.
`timescale 1ns / 1ps
`include "sorted_set_enter_leave_delta_macros.svh"
module sseld_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  sseld_pkg::dp_status_t st,
	output sseld_pkg::dp_cmd_t    cmd
);
	import sseld_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_CHECK = 9'b000000010,
		S_READ  = 9'b000000100,
		S_CMP   = 9'b000001000,
		S_ENTER = 9'b000010000,
		S_TREAD = 9'b000100000,
		S_TCMP  = 9'b001000000,
		S_DONE  = 9'b010000000,
		S_FLUSH = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_d;
	state_t after_id;

	assign in_ready = state_q == S_IDLE;
	assign after_id = st.eof ? S_TREAD : S_FLUSH;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (st.has_id && !st.order_bad) begin
					state_d = S_READ;
				end else begin
					cmd.flag_order = st.has_id;
					state_d        = after_id;
				end
			end
			S_READ: begin
				if (st.rd_avail) begin
					cmd.rd_issue = 1'b1;
					state_d      = S_CMP;
				end else begin
					state_d = S_ENTER;
				end
			end
			S_CMP: begin
				if (st.lt) begin
					if (st.can_emit) begin
						cmd.emit   = 1'b1;
						cmd.kind   = EV_LEAVE;
						cmd.rd_inc = 1'b1;
						state_d    = S_READ;
					end
				end else if (st.eq) begin
					cmd.rd_inc = 1'b1;
					cmd.store  = 1'b1;
					state_d    = after_id;
				end else begin
					state_d = S_ENTER;
				end
			end
			S_ENTER: begin
				if (st.can_emit) begin
					cmd.emit  = 1'b1;
					cmd.kind  = EV_ENTER;
					cmd.store = 1'b1;
					state_d   = after_id;
				end
			end
			S_TREAD: begin
				if (st.rd_avail) begin
					cmd.rd_issue = 1'b1;
					state_d      = S_TCMP;
				end else begin
					state_d = S_DONE;
				end
			end
			S_TCMP: begin
				if (st.can_emit) begin
					cmd.emit   = 1'b1;
					cmd.kind   = EV_LEAVE;
					cmd.rd_inc = 1'b1;
					state_d    = S_TREAD;
				end
			end
			S_DONE: begin
				if (st.can_emit) begin
					cmd.emit   = 1'b1;
					cmd.kind   = EV_DONE;
					cmd.commit = 1'b1;
					state_d    = S_FLUSH;
				end
			end
			S_FLUSH: begin
				if (!st.pend_valid) begin
					state_d = S_IDLE;
				end else if (st.out_free) begin
					cmd.flush = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`SSELD_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	`SSELD_ASSERT_IMP(a_emit_has_room, clk, arst_n, cmd.emit, st.can_emit)
	`SSELD_ASSERT_NEXT(a_flush_ends_item, clk, arst_n, cmd.flush, state_q == S_IDLE)

endmodule

// File: hw/rtl/sorted_set_enter_leave_delta.sv
// Top level of the sorted set enter/leave delta block: joins the merge
// controller and the datapath. Uses sseld_pkg, sseld_ctrl and sseld_dp.
//
//   channel   signals                        payload
//   input     in_valid / in_ready            in_data  (sseld_pkg::in_item_t)
//   output    out_valid / out_ready          out_data (sseld_pkg::out_item_t)
//
// An id request passes S_IDLE and S_CHECK, then S_READ and S_CMP for each old-list
// entry visited, as the id store has one registered read port; smaller old ids are
// reported as leave. It ends on a match, or in S_ENTER when an old id is larger or the
// old list is used up. An empty or dropped request skips the merge after S_CHECK.
// A closing request then reports each remaining old id as leave via S_TREAD and S_TCMP.
// Reset clears all control state, counts and bank selects at once; the id store
// is not cleared. A low out_ready stalls the sequencer once two results are held.
`timescale 1ns / 1ps
module sorted_set_enter_leave_delta (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  sseld_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output sseld_pkg::out_item_t out_data
);
	import sseld_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t st;

	sseld_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	sseld_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.st        (st),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
